>>> rtl/hcb_pkg.sv
// Package for the Huffman code builder: beat structs, field widths and
// parameter defaults. Depends on nothing; used by huffman_code_builder_top.
`default_nettype none

package hcb_pkg;

  // Parameter defaults
  localparam int MAX_SYMBOLS_DEF = 16;
  localparam int WEIGHT_BITS_DEF = 16;

  // Fixed field widths
  localparam int SYM_W      = 8;
  localparam int WEIGHT_W   = 16;
  localparam int CFG_W      = 5;
  localparam int LEN_OUT_W  = 4;
  localparam int CODE_W     = 15;
  localparam int CODE_LIMIT = 15;

  typedef struct packed {
    logic [SYM_W-1:0]    symbol;
    logic [WEIGHT_W-1:0] weight;
  } in_beat_t;

  typedef struct packed {
    logic [SYM_W-1:0]     out_symbol;
    logic [LEN_OUT_W-1:0] code_length;
    logic [CODE_W-1:0]    code_bits;
    logic                 last;
  } out_beat_t;

endpackage

`default_nettype wire

>>> rtl/huffman_code_builder_top.sv
// Huffman code builder: loads n leaves, builds the tree, emits one code per leaf.
// Flow: loads one leaf per accepted beat, then builds nodes top = n..2n-2, each by a
//   scan of the unparented nodes and a merge, then walks each leaf up to the root to emit
//   its code (one read port). Takes one set of n leaves at a time.
// Reset: synchronous active-low rst_n; symbol_count = 16, load count and parent
//   flags cleared; node RAMs are not cleared (every entry is written before use).
`default_nettype none

module huffman_code_builder_top import hcb_pkg::*; #(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_beat_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_beat_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int SYM_IDX_W  = $clog2(MAX_SYMBOLS);
  localparam int CNT_W      = $clog2(MAX_SYMBOLS + 1);
  localparam int NODE_COUNT = 2 * MAX_SYMBOLS - 1;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int NW         = WEIGHT_BITS + SYM_IDX_W;
  localparam int WRAM_W     = SYM_W + NW;
  localparam int PRAM_W     = NODE_W + 1;
  localparam int LEN_W      = (SYM_IDX_W > LEN_OUT_W) ? SYM_IDX_W : LEN_OUT_W;
  localparam logic [NW-1:0] WMASK = NW'((64'd1 << WEIGHT_BITS) - 64'd1);

  typedef enum logic [6:0] {
    S_LOAD    = 7'b0000001,
    S_SCAN    = 7'b0000010,
    S_MRG_A   = 7'b0000100,
    S_MRG_B   = 7'b0001000,
    S_WALK_RD = 7'b0010000,
    S_WALK_UP = 7'b0100000,
    S_EMIT    = 7'b1000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CFG_W-1:0]        symbol_count_r, symbol_count_nxt;
  logic [CNT_W-1:0]        load_cnt_r, load_cnt_nxt;
  logic [NODE_COUNT-1:0]   has_par_r, has_par_nxt;
  logic [NODE_W-1:0]       top_r, top_nxt;
  logic [NODE_W-1:0]       scan_addr_r, scan_addr_nxt;
  logic                    q_vld_r, q_vld_nxt;
  logic [NODE_W-1:0]       q_idx_r, q_idx_nxt;
  logic                    a_vld_r, a_vld_nxt;
  logic [NODE_W-1:0]       a_idx_r, a_idx_nxt;
  logic [NW-1:0]           a_w_r, a_w_nxt;
  logic                    b_vld_r, b_vld_nxt;
  logic [NODE_W-1:0]       b_idx_r, b_idx_nxt;
  logic [NW-1:0]           b_w_r, b_w_nxt;
  logic [SYM_IDX_W-1:0]    walk_i_r, walk_i_nxt;
  logic [NODE_W-1:0]       cur_r, cur_nxt;
  logic [LEN_W-1:0]        len_r, len_nxt;
  logic [CODE_W-1:0]       code_r, code_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_beat_t               out_data_r, out_data_nxt;

  // RAM ports
  logic                    w_we;
  logic [NODE_W-1:0]       w_waddr, w_raddr;
  logic [WRAM_W-1:0]       w_wdata, w_rdata;
  logic                    p_we;
  logic [NODE_W-1:0]       p_waddr;
  logic [PRAM_W-1:0]       p_wdata, p_rdata;

  // derived values
  logic [CNT_W-1:0]        n_eff;
  logic [CNT_W:0]          two_n;
  logic [NODE_W-1:0]       node_last;
  logic [NW-1:0]           q_w;
  logic [NW-1:0]           in_w;
  logic                    load_done;
  logic                    walk_last;
  logic                    in_acc;

  // weight/symbol store: {symbol, weight} per node, symbol meaningful on leaves
  hcb_ram #(.WIDTH(WRAM_W), .DEPTH(NODE_COUNT)) u_wram (
    .clk     (clk),
    .we      (w_we),
    .wr_addr (w_waddr),
    .wr_data (w_wdata),
    .rd_addr (w_raddr),
    .rd_data (w_rdata)
  );

  // parent store: {is_left, parent index} per node
  hcb_ram #(.WIDTH(PRAM_W), .DEPTH(NODE_COUNT)) u_pram (
    .clk     (clk),
    .we      (p_we),
    .wr_addr (p_waddr),
    .wr_data (p_wdata),
    .rd_addr (cur_r),
    .rd_data (p_rdata)
  );

  // clamp the leaf count to 1..MAX_SYMBOLS
  always_comb begin
    if (symbol_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(symbol_count_r) > MAX_SYMBOLS) begin
      n_eff = CNT_W'(MAX_SYMBOLS);
    end else begin
      n_eff = CNT_W'(symbol_count_r);
    end
  end

  assign two_n     = {n_eff, 1'b0};
  assign node_last = NODE_W'(two_n - (CNT_W+1)'(2));
  assign q_w       = w_rdata[NW-1:0];
  assign in_w      = NW'(in_data.weight) & WMASK;
  assign in_ready  = (state_r == S_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign load_done = (CNT_W'(load_cnt_r + CNT_W'(1)) >= n_eff);
  assign walk_last = ((CNT_W'(walk_i_r) + CNT_W'(1)) == n_eff);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // weight RAM read address: node scan during merges, leaf symbol during walks
  assign w_raddr = (state_r == S_SCAN) ? scan_addr_r : NODE_W'(walk_i_r);

  // main sequencer
  always_comb begin
    state_nxt        = state_r;
    symbol_count_nxt = symbol_count_r;
    load_cnt_nxt     = load_cnt_r;
    has_par_nxt      = has_par_r;
    top_nxt          = top_r;
    scan_addr_nxt    = scan_addr_r;
    q_vld_nxt        = 1'b0;
    q_idx_nxt        = scan_addr_r;
    a_vld_nxt        = a_vld_r;
    a_idx_nxt        = a_idx_r;
    a_w_nxt          = a_w_r;
    b_vld_nxt        = b_vld_r;
    b_idx_nxt        = b_idx_r;
    b_w_nxt          = b_w_r;
    walk_i_nxt       = walk_i_r;
    cur_nxt          = cur_r;
    len_nxt          = len_r;
    code_nxt         = code_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;
    w_we             = 1'b0;
    w_waddr          = NODE_W'(load_cnt_r);
    w_wdata          = {in_data.symbol, in_w};
    p_we             = 1'b0;
    p_waddr          = a_idx_r;
    p_wdata          = {1'b1, top_r};

    // output register drains independently of the sequencer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // store each leaf; on the last one start the build (the walk for a single leaf)
      S_LOAD: begin
        if (in_acc) begin
          w_we = 1'b1;
          if (load_done) begin
            load_cnt_nxt = '0;
            has_par_nxt  = '0;
            walk_i_nxt   = '0;
            cur_nxt      = '0;
            len_nxt      = '0;
            code_nxt     = '0;
            if (n_eff == CNT_W'(1)) begin
              state_nxt = S_WALK_RD;
            end else begin
              top_nxt       = NODE_W'(n_eff);
              scan_addr_nxt = '0;
              a_vld_nxt     = 1'b0;
              b_vld_nxt     = 1'b0;
              state_nxt     = S_SCAN;
            end
          end else begin
            load_cnt_nxt = CNT_W'(load_cnt_r + CNT_W'(1));
          end
        end
      end

      // stream nodes 0..top-1, keep the two lightest unparented ones
      S_SCAN: begin
        if (scan_addr_r < top_r) begin
          q_vld_nxt     = 1'b1;
          scan_addr_nxt = scan_addr_r + NODE_W'(1);
        end
        if (q_vld_r && !has_par_r[q_idx_r]) begin
          if (!a_vld_r || (q_w < a_w_r)) begin
            b_vld_nxt = a_vld_r;
            b_idx_nxt = a_idx_r;
            b_w_nxt   = a_w_r;
            a_vld_nxt = 1'b1;
            a_idx_nxt = q_idx_r;
            a_w_nxt   = q_w;
          end else if (!b_vld_r || (q_w < b_w_r)) begin
            b_vld_nxt = 1'b1;
            b_idx_nxt = q_idx_r;
            b_w_nxt   = q_w;
          end
        end
        if (!(scan_addr_r < top_r) && !q_vld_r) begin
          state_nxt = S_MRG_A;
        end
      end

      // new node weight, left child link
      S_MRG_A: begin
        w_we    = 1'b1;
        w_waddr = top_r;
        w_wdata = {{SYM_W{1'b0}}, NW'(a_w_r + b_w_r)};
        p_we    = 1'b1;
        p_waddr = a_idx_r;
        p_wdata = {1'b1, top_r};
        has_par_nxt[a_idx_r] = 1'b1;
        has_par_nxt[b_idx_r] = 1'b1;
        state_nxt = S_MRG_B;
      end

      // right child link; next merge or start the code walks
      S_MRG_B: begin
        p_we    = 1'b1;
        p_waddr = b_idx_r;
        p_wdata = {1'b0, top_r};
        if (top_r == node_last) begin
          state_nxt = S_WALK_RD;
        end else begin
          top_nxt       = top_r + NODE_W'(1);
          scan_addr_nxt = '0;
          a_vld_nxt     = 1'b0;
          b_vld_nxt     = 1'b0;
          state_nxt     = S_SCAN;
        end
      end

      // climb while the current node has a parent
      S_WALK_RD: begin
        if (has_par_r[cur_r]) begin
          state_nxt = S_WALK_UP;
        end else begin
          state_nxt = S_EMIT;
        end
      end

      // parent entry is back: record the branch bit and move up
      S_WALK_UP: begin
        if (!p_rdata[NODE_W] && (len_r < LEN_W'(CODE_LIMIT))) begin
          code_nxt = code_r | (CODE_W'(1) << len_r[LEN_OUT_W-1:0]);
        end
        len_nxt   = len_r + LEN_W'(1);
        cur_nxt   = p_rdata[NODE_W-1:0];
        state_nxt = S_WALK_RD;
      end

      // hand the code to the output register when it is free
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_symbol  = w_rdata[WRAM_W-1 -: SYM_W];
          out_data_nxt.code_length = len_r[LEN_OUT_W-1:0];
          out_data_nxt.code_bits   = code_r;
          out_data_nxt.last        = walk_last;
          if (walk_last) begin
            state_nxt = S_LOAD;
          end else begin
            walk_i_nxt = walk_i_r + SYM_IDX_W'(1);
            cur_nxt    = NODE_W'(walk_i_r + SYM_IDX_W'(1));
            len_nxt    = '0;
            code_nxt   = '0;
            state_nxt  = S_WALK_RD;
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // register write also clears the load count
    if (cfg_we) begin
      symbol_count_nxt = cfg_wdata;
      load_cnt_nxt     = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_LOAD;
      symbol_count_r <= CFG_W'(16);
      load_cnt_r     <= '0;
      has_par_r      <= '0;
      q_vld_r        <= 1'b0;
      a_vld_r        <= 1'b0;
      b_vld_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      symbol_count_r <= symbol_count_nxt;
      load_cnt_r     <= load_cnt_nxt;
      has_par_r      <= has_par_nxt;
      q_vld_r        <= q_vld_nxt;
      a_vld_r        <= a_vld_nxt;
      b_vld_r        <= b_vld_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    top_r       <= top_nxt;
    scan_addr_r <= scan_addr_nxt;
    q_idx_r     <= q_idx_nxt;
    a_idx_r     <= a_idx_nxt;
    a_w_r       <= a_w_nxt;
    b_idx_r     <= b_idx_nxt;
    b_w_r       <= b_w_nxt;
    walk_i_r    <= walk_i_nxt;
    cur_r       <= cur_nxt;
    len_r       <= len_nxt;
    code_r      <= code_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/hcb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instanced for the node stores of the code builder.
`default_nettype none

module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire
